/* rtl/pim_pkg.sv */
`default_nettype none

package pim_pkg;

    // Volume bounds
    localparam int MAX_X_DEF = 32;
    localparam int MAX_Y_DEF = 32;
    localparam int MAX_Z_DEF = 32;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int DIFF_W   = 17;
    localparam int METRIC_W = 40;
    localparam int CFG_W    = 6;
    localparam int CFG_IDX_W = 2;

    // Term unit: den = 100 + d^2 with |d| < 2^17, quotient at most 65536
    localparam int DEN_W  = 35;
    localparam int QUO_W  = 17;
    localparam int ABS_W  = 17;
    localparam longint unsigned TERM_NUM2 = 64'd13107200;  // 2 * 100 * 2^16
    localparam int TERM_BASE = 100;

    // Neighborhood
    localparam int OFS_MIN   = -3;
    localparam int OFS_MAX   = 3;
    localparam int RADIUS_SQ = 9;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd3;

    // One stored voxel
    typedef struct packed {
        logic              mask;
        logic [DIFF_W-1:0] diff;
    } voxel_t;

endpackage

`default_nettype wire

/* rtl/pim_ram.sv */
`default_nettype none

module pim_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 32768
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

`default_nettype wire

/* rtl/pim_term_div.sv */
`default_nettype none

module pim_term_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [pim_pkg::DEN_W-1:0]   den,
    output logic                             done,
    output logic      [pim_pkg::QUO_W-1:0]   quo
);
    import pim_pkg::*;

    localparam int CW = $clog2(QUO_W + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [DEN_W:0]  rem_reg, rem_next;
    logic [DEN_W:0]  div_reg, div_next;
    logic [QUO_W-1:0] bits_reg, bits_next;
    logic [QUO_W-1:0] q_reg, q_next;
    logic [DEN_W:0]  num;
    logic [DEN_W+1:0] sh;
    logic            ge;

    // round(2N + den) / (2 den): quotient fits QUO_W bits, so start from the top bits
    assign num = (DEN_W+1)'(TERM_NUM2) + {1'b0, den};
    assign sh  = {rem_reg, bits_reg[QUO_W-1]};
    assign ge  = sh >= {1'b0, div_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        bits_next = bits_reg;
        q_next    = q_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(QUO_W);
            rem_next  = (DEN_W+1)'(num[DEN_W:QUO_W]);
            bits_next = num[QUO_W-1:0];
            div_next  = {den, 1'b0};
            q_next    = '0;
        end else if (busy_reg) begin
            // One restoring step per cycle
            rem_next  = ge ? (DEN_W+1)'(sh - {1'b0, div_reg}) : (DEN_W+1)'(sh);
            bits_next = {bits_reg[QUO_W-2:0], 1'b0};
            q_next    = {q_reg[QUO_W-2:0], ge};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        bits_reg <= bits_next;
        q_reg    <= q_next;
    end

    assign done = done_reg;
    assign quo  = q_reg;

endmodule

`default_nettype wire

/* rtl/pattern_intensity_metric.sv */
// Load: one voxel per cycle, while s_tready is high, into the voxel RAM (difference
// and stencil bit). Sum: after the last voxel, each centre is read and its stencil bit
// checked; for an included centre, each of the 343 cube offsets is skipped (outside
// radius) or read, squared, passed through the 17-step term divider and accumulated.
// The result is offered after the whole sum; one result per volume.
// Reset (aresetn low, synchronous) restores size 32x32x32, clears the load count,
// accumulator and handshakes; RAM contents are left as they are. A size write holds off
// input while the volume size settles.
`default_nettype none

module pattern_intensity_metric #(
    parameter int MAX_X = pim_pkg::MAX_X_DEF,
    parameter int MAX_Y = pim_pkg::MAX_Y_DEF,
    parameter int MAX_Z = pim_pkg::MAX_Z_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [pim_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [pim_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [31:0]                     s_tdata,   // sample_a, sample_b
    input  wire logic                            s_tuser,   // in_mask
    input  wire logic                            s_tlast,   // last_voxel
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pim_pkg::METRIC_W-1:0]         m_tdata,   // metric
    output logic                                 m_tuser    // saturated
);
    import pim_pkg::*;

    localparam int XW    = $clog2(MAX_X + 1);
    localparam int YW    = $clog2(MAX_Y + 1);
    localparam int ZW    = $clog2(MAX_Z + 1);
    localparam int DEPTH = MAX_X * MAX_Y * MAX_Z;
    localparam int AW    = $clog2(DEPTH);
    localparam int TW    = $clog2(DEPTH + 1);
    localparam int SXYW  = $clog2(MAX_X * MAX_Y + 1);
    localparam int NW    = AW + 3;
    localparam int VW    = $bits(voxel_t);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CRD  = 4'd1;
    localparam logic [3:0] S_CCHK = 4'd2;
    localparam logic [3:0] S_NADR = 4'd3;
    localparam logic [3:0] S_NDAT = 4'd4;
    localparam logic [3:0] S_SQ   = 4'd5;
    localparam logic [3:0] S_DIVS = 4'd6;
    localparam logic [3:0] S_DIVW = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    // Configuration
    logic [CFG_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic             reverse_reg;
    logic [1:0]       settle_reg;
    logic [XW-1:0]    sx;
    logic [YW-1:0]    sy;
    logic [ZW-1:0]    sz;
    logic [SXYW-1:0]  sxy_reg;
    logic [TW-1:0]    total_reg;

    // Control
    logic [3:0]       state_reg, state_next;
    logic [AW-1:0]    lc_reg, lc_next;
    logic [XW-1:0]    cx_reg, cx_next;
    logic [YW-1:0]    cy_reg, cy_next;
    logic [ZW-1:0]    cz_reg, cz_next;
    logic [AW-1:0]    ca_reg, ca_next;
    logic signed [2:0] dx_reg, dx_next, dy_reg, dy_next, dz_reg, dz_next;
    logic             inb_reg, inb_next;
    logic [METRIC_W-1:0] acc_reg, acc_next;
    logic             sat_reg, sat_next;
    logic             mv_reg, mv_next;

    // Payload
    logic signed [DIFF_W-1:0] dc_reg, dc_next;
    logic signed [DIFF_W:0]   d_reg, d_next;
    logic [DEN_W-1:0]         den_reg, den_next;
    logic [METRIC_W-1:0]      mdata_reg, mdata_next;
    logic                     muser_reg, muser_next;

    // RAM and divider
    logic          ram_we;
    logic [AW-1:0] ram_addr;
    voxel_t        ram_wdata, ram_rdata;
    logic          div_start, div_done;
    logic [QUO_W-1:0] div_quo;

    logic          s_acc, m_acc;
    logic [AW-1:0] ld_addr;
    logic [TW-1:0] ld_inc;
    logic signed [XW+1:0] rx;
    logic signed [YW+1:0] ry;
    logic signed [ZW+1:0] rz;
    logic          in_bounds, in_radius, last_ofs, last_ctr;
    logic signed [NW-1:0] nsum;
    logic [AW-1:0] naddr;
    logic [ABS_W:0] d_abs;
    logic [METRIC_W:0] acc_sum;
    logic [5:0]    rsq;

    // Effective sizes: zero reads as one, oversize clamps
    assign sx = (size_x_reg == '0) ? XW'(1) :
                (32'(size_x_reg) > MAX_X) ? XW'(MAX_X) : XW'(size_x_reg);
    assign sy = (size_y_reg == '0) ? YW'(1) :
                (32'(size_y_reg) > MAX_Y) ? YW'(MAX_Y) : YW'(size_y_reg);
    assign sz = (size_z_reg == '0) ? ZW'(1) :
                (32'(size_z_reg) > MAX_Z) ? ZW'(MAX_Z) : ZW'(size_z_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_x_reg  <= CFG_W'(32);
            size_y_reg  <= CFG_W'(32);
            size_z_reg  <= CFG_W'(32);
            reverse_reg <= 1'b0;
            settle_reg  <= 2'd2;
        end else begin
            if (cfg_wr_en) begin
                settle_reg <= 2'd2;
                unique case (cfg_index)
                    CFG_SIZE_X:  size_x_reg  <= cfg_data;
                    CFG_SIZE_Y:  size_y_reg  <= cfg_data;
                    CFG_SIZE_Z:  size_z_reg  <= cfg_data;
                    CFG_REVERSE: reverse_reg <= cfg_data[0];
                    default: ;
                endcase
            end else if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 1'b1;
            end
        end
        // Slice and volume size, one multiply per stage
        sxy_reg   <= SXYW'(SXYW'(sx) * SXYW'(sy));
        total_reg <= TW'(TW'(sxy_reg) * TW'(sz));
    end

    assign s_tready = (state_reg == S_IDLE) && (settle_reg == 2'd0);
    assign s_acc    = s_tvalid && s_tready;
    assign m_acc    = mv_reg && m_tready;

    // Load address with wrap
    assign ld_addr = (TW'(lc_reg) >= total_reg) ? '0 : lc_reg;
    assign ld_inc  = TW'(ld_addr) + 1'b1;

    // Neighbor coordinates and address
    assign rx = $signed({2'b00, cx_reg}) + (XW+2)'(dx_reg);
    assign ry = $signed({2'b00, cy_reg}) + (YW+2)'(dy_reg);
    assign rz = $signed({2'b00, cz_reg}) + (ZW+2)'(dz_reg);
    assign in_bounds = (rx >= 0) && (rx < $signed({2'b00, sx})) &&
                       (ry >= 0) && (ry < $signed({2'b00, sy})) &&
                       (rz >= 0) && (rz < $signed({2'b00, sz}));
    assign rsq = 6'(dx_reg * dx_reg) + 6'(dy_reg * dy_reg) + 6'(dz_reg * dz_reg);
    assign in_radius = rsq <= 6'(RADIUS_SQ);
    assign nsum = $signed(NW'(ca_reg)) + NW'(dx_reg)
                + NW'(dy_reg) * $signed(NW'(sx))
                + NW'(dz_reg) * $signed(NW'(sxy_reg));
    assign naddr = nsum[AW-1:0];

    assign last_ofs = (dx_reg == 3'(OFS_MAX)) && (dy_reg == 3'(OFS_MAX)) &&
                      (dz_reg == 3'(OFS_MAX));
    assign last_ctr = (cx_reg == sx - 1'b1) && (cy_reg == sy - 1'b1) &&
                      (cz_reg == sz - 1'b1);

    assign d_abs   = d_reg[DIFF_W] ? (ABS_W+1)'(-d_reg) : (ABS_W+1)'(d_reg);
    assign acc_sum = {1'b0, acc_reg} + (METRIC_W+1)'(div_quo);

    // RAM port: load writes in idle, sweep reads otherwise
    assign ram_we = s_acc;
    assign ram_wdata.mask = s_tuser;
    assign ram_wdata.diff = DIFF_W'($signed(s_tdata[15:0])) - DIFF_W'($signed(s_tdata[31:16]));
    assign ram_addr = (state_reg == S_IDLE) ? ld_addr :
                      (state_reg == S_CRD)  ? ca_reg  : naddr;
    assign div_start = (state_reg == S_DIVS);

    always_comb begin
        state_next = state_reg;
        lc_next    = lc_reg;
        cx_next    = cx_reg;
        cy_next    = cy_reg;
        cz_next    = cz_reg;
        ca_next    = ca_reg;
        dx_next    = dx_reg;
        dy_next    = dy_reg;
        dz_next    = dz_reg;
        inb_next   = inb_reg;
        acc_next   = acc_reg;
        sat_next   = sat_reg;
        mv_next    = m_acc ? 1'b0 : mv_reg;
        dc_next    = dc_reg;
        d_next     = d_reg;
        den_next   = den_reg;
        mdata_next = mdata_reg;
        muser_next = muser_reg;

        unique case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    lc_next = (ld_inc >= total_reg) ? '0 : AW'(ld_inc);
                    if (s_tlast) begin
                        lc_next    = '0;
                        cx_next    = '0;
                        cy_next    = '0;
                        cz_next    = '0;
                        ca_next    = '0;
                        acc_next   = '0;
                        sat_next   = 1'b0;
                        state_next = S_CRD;
                    end
                end
            end
            S_CRD: state_next = S_CCHK;
            S_CCHK: begin
                dc_next = $signed(ram_rdata.diff);
                dx_next = 3'(OFS_MIN);
                dy_next = 3'(OFS_MIN);
                dz_next = 3'(OFS_MIN);
                if ((ram_rdata.mask ^ reverse_reg) == 1'b0) begin
                    state_next = S_NADR;
                    state_next = S_CRD;
                end else begin
                    state_next = S_NADR;
                end
            end
            S_NADR: begin
                inb_next = in_bounds;
                if (in_radius) begin
                    state_next = S_NDAT;
                end
            end
            S_NDAT: begin
                d_next     = (DIFF_W+1)'(dc_reg) -
                             (inb_reg ? (DIFF_W+1)'($signed(ram_rdata.diff)) : '0);
                state_next = S_SQ;
            end
            S_SQ: begin
                den_next   = DEN_W'(TERM_BASE) + DEN_W'(d_abs[ABS_W-1:0] * d_abs[ABS_W-1:0]);
                state_next = S_DIVS;
            end
            S_DIVS: state_next = S_DIVW;
            S_DIVW: begin
                if (div_done) begin
                    if (acc_sum[METRIC_W]) begin
                        acc_next = '1;
                        sat_next = 1'b1;
                    end else begin
                        acc_next = acc_sum[METRIC_W-1:0];
                    end
                    state_next = S_NADR;
                end
            end
            S_DONE: begin
                if (!mv_reg || m_tready) begin
                    mv_next    = 1'b1;
                    mdata_next = acc_reg;
                    muser_next = sat_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase

        // Advance offset after a skipped or finished term, then the centre; skip an excluded centre
        if ((state_reg == S_NADR && !in_radius) || (state_reg == S_DIVW && div_done) ||
            (state_reg == S_CCHK && (ram_rdata.mask ^ reverse_reg) == 1'b0)) begin
            if (state_reg != S_CCHK && !last_ofs) begin
                if (dx_reg != 3'(OFS_MAX)) begin
                    dx_next = dx_reg + 1'b1;
                end else begin
                    dx_next = 3'(OFS_MIN);
                    if (dy_reg != 3'(OFS_MAX)) begin
                        dy_next = dy_reg + 1'b1;
                    end else begin
                        dy_next = 3'(OFS_MIN);
                        dz_next = dz_reg + 1'b1;
                    end
                end
                state_next = S_NADR;
            end else begin
                ca_next = ca_reg + 1'b1;
                if (cx_reg != sx - 1'b1) begin
                    cx_next = cx_reg + 1'b1;
                end else begin
                    cx_next = '0;
                    if (cy_reg != sy - 1'b1) begin
                        cy_next = cy_reg + 1'b1;
                    end else begin
                        cy_next = '0;
                        cz_next = cz_reg + 1'b1;
                    end
                end
                state_next = last_ctr ? S_DONE : S_CRD;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            lc_reg    <= '0;
            cx_reg    <= '0;
            cy_reg    <= '0;
            cz_reg    <= '0;
            ca_reg    <= '0;
            dx_reg    <= '0;
            dy_reg    <= '0;
            dz_reg    <= '0;
            inb_reg   <= 1'b0;
            acc_reg   <= '0;
            sat_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            lc_reg    <= lc_next;
            cx_reg    <= cx_next;
            cy_reg    <= cy_next;
            cz_reg    <= cz_next;
            ca_reg    <= ca_next;
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            dz_reg    <= dz_next;
            inb_reg   <= inb_next;
            acc_reg   <= acc_next;
            sat_reg   <= sat_next;
            mv_reg    <= mv_next;
        end
        dc_reg    <= dc_next;
        d_reg     <= d_next;
        den_reg   <= den_next;
        mdata_reg <= mdata_next;
        muser_reg <= muser_next;
    end

    pim_ram #(
        .WIDTH (VW),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    pim_term_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .den     (den_reg),
        .done    (div_done),
        .quo     (div_quo)
    );

    assign m_tvalid = mv_reg;
    assign m_tdata  = mdata_reg;
    assign m_tuser  = muser_reg;

endmodule

`default_nettype wire

/* rtl/pim_checker.sv */
`default_nettype none

module pim_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            cfg_wr_en,
    input wire logic                            s_tvalid,
    input wire logic                            s_tready,
    input wire logic                            s_tlast,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [pim_pkg::METRIC_W-1:0]    m_tdata,
    input wire logic                            m_tuser
);
    import pim_pkg::*;

    // Hold a stalled result
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result dropped or changed while stalled");

    // A register write stalls input on the next cycle
    a_cfg_settle: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr_en |=> !s_tready)
        else $error("input taken right after a register write");

    // The last voxel starts the sum and closes the input
    a_last_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast |=> !s_tready)
        else $error("input still open after last voxel");

    // Saturation leaves the metric at full scale
    a_sat_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == {METRIC_W{1'b1}})
        else $error("saturated flag without full-scale metric");

    // The last voxel transfer cannot return a result in the next cycle
    a_no_instant: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tlast && !m_tvalid |=> !m_tvalid)
        else $error("result appeared before the sum ran");

endmodule

bind pattern_intensity_metric pim_checker u_pim_checker (.*);

`default_nettype wire

/* tb/pim_checker.sv */
`timescale 1ns / 1ps

module pim_tb_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [pim_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [pim_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [31:0]                   s_tdata,
    input  wire logic                          s_tuser,
    input  wire logic                          s_tlast,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [pim_pkg::METRIC_W-1:0]  m_tdata,
    input  wire logic                          m_tuser,
    output int                                 errors,
    output int                                 pending
);
    import pim_pkg::*;

    localparam int VOXELS = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
    localparam longint unsigned METRIC_FULL = (64'd1 << METRIC_W) - 1;

    typedef struct {
        logic [METRIC_W-1:0] metric;
        logic                saturated;
    } metric_t;

    // Shadow of the voxel RAM and the register file
    int            voxel_diff [VOXELS];
    bit            voxel_mask [VOXELS];
    int unsigned   dim_x, dim_y, dim_z, load_ptr;
    bit            invert_sel;
    metric_t       metric_q [$];

    initial begin
        errors = 0;
        for (int i = 0; i < VOXELS; i++) begin
            voxel_diff[i] = 0;
            voxel_mask[i] = 0;
        end
    end

    assign pending = metric_q.size();

    function automatic int unsigned clamp_dim(int unsigned v, int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // Rounded Q1.16 value of 100/(100+d^2), ties up
    function automatic longint unsigned intensity_term(longint d);
        longint unsigned mag, den;
        mag = (d < 0) ? -d : d;
        den = TERM_BASE + mag * mag;
        return (TERM_NUM2 + den) / (2 * den);
    endfunction

    function automatic metric_t sum_pattern_intensity();
        metric_t         r;
        int unsigned     sx, sy, sz;
        longint unsigned acc, t;
        longint          dc, dn;
        int              rx, ry, rz;
        sx = clamp_dim(dim_x, MAX_X_DEF);
        sy = clamp_dim(dim_y, MAX_Y_DEF);
        sz = clamp_dim(dim_z, MAX_Z_DEF);
        acc = 0;
        r.saturated = 0;
        for (int z = 0; z < sz; z++)
            for (int y = 0; y < sy; y++)
                for (int x = 0; x < sx; x++) begin
                    if ((voxel_mask[x + sx * (y + sy * z)] ^ invert_sel) == 1'b0) continue;
                    dc = voxel_diff[x + sx * (y + sy * z)];
                    for (int oz = OFS_MIN; oz <= OFS_MAX; oz++)
                        for (int oy = OFS_MIN; oy <= OFS_MAX; oy++)
                            for (int ox = OFS_MIN; ox <= OFS_MAX; ox++) begin
                                if (ox * ox + oy * oy + oz * oz > RADIUS_SQ) continue;
                                rx = x + ox;
                                ry = y + oy;
                                rz = z + oz;
                                dn = 0;
                                // neighbors off the volume read as zero difference
                                if (rx >= 0 && rx < sx && ry >= 0 && ry < sy &&
                                    rz >= 0 && rz < sz)
                                    dn = voxel_diff[rx + sx * (ry + sy * rz)];
                                t = intensity_term(dc - dn);
                                if (acc > METRIC_FULL - t) begin
                                    acc = METRIC_FULL;
                                    r.saturated = 1;
                                end else begin
                                    acc += t;
                                end
                            end
                end
        r.metric = acc[METRIC_W-1:0];
        return r;
    endfunction

    task automatic store_voxel();
        int unsigned total;
        total = clamp_dim(dim_x, MAX_X_DEF) * clamp_dim(dim_y, MAX_Y_DEF)
              * clamp_dim(dim_z, MAX_Z_DEF);
        if (load_ptr >= total) load_ptr = 0;
        voxel_diff[load_ptr] = int'($signed(s_tdata[15:0])) - int'($signed(s_tdata[31:16]));
        voxel_mask[load_ptr] = s_tuser;
        load_ptr = (load_ptr + 1 >= total) ? 0 : load_ptr + 1;
        if (s_tlast) begin
            metric_q.push_back(sum_pattern_intensity());
            load_ptr = 0;
        end
    endtask

    task automatic compare_metric();
        metric_t want;
        if (metric_q.size() == 0) begin
            $display("%0t: unexpected transfer metric=%h saturated=%b",
                     $time, m_tdata, m_tuser);
            errors++;
            return;
        end
        want = metric_q.pop_front();
        if (m_tdata !== want.metric) begin
            $display("%0t: metric expected %h actual %h", $time, want.metric, m_tdata);
            errors++;
        end
        if (m_tuser !== want.saturated) begin
            $display("%0t: saturated expected %b actual %b",
                     $time, want.saturated, m_tuser);
            errors++;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            dim_x = MAX_X_DEF;
            dim_y = MAX_Y_DEF;
            dim_z = MAX_Z_DEF;
            invert_sel = 0;
            load_ptr = 0;
            metric_q.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_SIZE_X:  dim_x = cfg_data;
                    CFG_SIZE_Y:  dim_y = cfg_data;
                    CFG_SIZE_Z:  dim_z = cfg_data;
                    CFG_REVERSE: invert_sel = cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) store_voxel();
            if (m_tvalid && m_tready) compare_metric();
        end
    end

endmodule

/* tb/tb_pattern_intensity_metric.sv */
`timescale 1ns / 1ps

module tb_pattern_intensity_metric;
    import pim_pkg::*;

    localparam int VOXELS      = MAX_X_DEF * MAX_Y_DEF * MAX_Z_DEF;
    localparam int CYCLE_LIMIT = 12_000_000;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic                   cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]   cfg_index = CFG_SIZE_X;
    logic [CFG_W-1:0]       cfg_data = '0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [31:0]            s_tdata = '0;
    logic                   s_tuser = 0;
    logic                   s_tlast = 0;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic [METRIC_W-1:0]    m_tdata;
    logic                   m_tuser;
    int                     errors, pending;
    int                     cycles = 0;
    int                     m_stall = 0;
    bit                     idle_on = 1;

    // Stimulus-side view of the load pointer, so no unwritten voxel gets read
    bit                     loaded [VOXELS];
    int unsigned            gen_x = 32, gen_y = 32, gen_z = 32, gen_ptr = 0;
    bit                     gen_rev = 0;

    always #2 aclk = ~aclk;

    pattern_intensity_metric i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    pim_tb_checker i_checker (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .s_tuser(s_tuser), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .errors(errors), .pending(pending)
    );

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Stall the result channel in random bursts
    always @(posedge aclk) begin
        if (m_stall > 0) begin
            m_stall <= m_stall - 1;
            m_tready <= 0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            m_stall <= $urandom_range(0, 16);
            m_tready <= 0;
        end else begin
            m_tready <= 1;
        end
    end

    function automatic int unsigned clamp_dim(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_X_DEF) return MAX_X_DEF;
        return v;
    endfunction

    function automatic int unsigned volume_total();
        return clamp_dim(gen_x) * clamp_dim(gen_y) * clamp_dim(gen_z);
    endfunction

    function automatic bit volume_loaded();
        for (int i = 0; i < volume_total(); i++)
            if (!loaded[i]) return 0;
        return 1;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        @(posedge aclk);
        cfg_wr_en <= 1;
        cfg_index <= idx;
        cfg_data  <= val[CFG_W-1:0];
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    // Drop the input, wait for the block to drain, then reshape the volume and set the stencil selection
    task automatic set_volume(input int unsigned x, y, z, input bit rev);
        s_tvalid <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        write_reg(CFG_SIZE_X, x);
        write_reg(CFG_SIZE_Y, y);
        write_reg(CFG_SIZE_Z, z);
        write_reg(CFG_REVERSE, rev);
        gen_x = x;
        gen_y = y;
        gen_z = z;
        gen_rev = rev;
    endtask

    task automatic send_voxel(input logic [15:0] a, b, input bit msk, lst);
        int unsigned total;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tdata  <= {b, a};
        s_tuser  <= msk;
        s_tlast  <= lst;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        // advance the stimulus copy of the load pointer
        total = volume_total();
        if (gen_ptr >= total) gen_ptr = 0;
        loaded[gen_ptr] = 1;
        gen_ptr = (gen_ptr + 1 >= total || lst) ? 0 : gen_ptr + 1;
    endtask

    // Random voxel: about one centre in five included, mixed sample ranges
    task automatic send_random_voxel(input bit lst);
        logic [15:0] a, b;
        bit          centre;
        centre = ($urandom_range(0, 4) == 0);
        a = 16'($urandom);
        if ($urandom_range(0, 1)) begin
            b = 16'($urandom);
        end else begin
            a = 16'(a % 41 - 20);
            b = 16'($urandom_range(0, 40) - 20);
        end
        send_voxel(a, b, centre ^ gen_rev, lst);
    endtask

    // Load n voxels; the last flag waits until every voxel of the volume holds data
    task automatic load_and_sum(input int unsigned n);
        int unsigned i;
        i = 0;
        while (i + 1 < n || !volume_loaded()) begin
            send_random_voxel(0);
            i++;
        end
        send_random_voxel(1);
    endtask

    initial begin
        int unsigned x, y, z, total, n, pick;
        int          sent;
        for (int i = 0; i < VOXELS; i++) loaded[i] = 0;
        repeat (12) @(posedge aclk);
        aresetn <= 1;

        // Directed: 2x2x1 with sample extremes, both stencil values
        set_volume(2, 2, 1, 0);
        send_voxel(16'h7fff, 16'h8000, 1, 0);
        send_voxel(16'h8000, 16'h7fff, 1, 0);
        send_voxel(16'h0000, 16'h0000, 0, 0);
        send_voxel(16'hffff, 16'h0005, 1, 1);
        // early last voxel reuses the older contents
        send_voxel(16'h0003, 16'hfffd, 1, 0);
        send_voxel(16'h0000, 16'h000a, 0, 1);
        // reversed stencil selection; the last two voxels keep their older contents
        set_volume(2, 2, 1, 1);
        send_voxel(16'h0001, 16'h0000, 0, 0);
        send_voxel(16'h0000, 16'h0001, 1, 1);
        // zero size reads as one voxel
        set_volume(0, 0, 0, 0);
        send_voxel(16'h7fff, 16'h8000, 1, 1);
        send_voxel(16'h1234, 16'h1230, 1, 1);
        // too many voxels wrap over the start
        set_volume(3, 1, 1, 0);
        for (int i = 0; i < 5; i++) send_voxel(16'(i * 7), 16'(16'hfff0 + i), 1, 0);
        send_voxel(16'h0000, 16'h8000, 1, 1);

        // Random volumes, mostly small, with the odd full-length row
        sent = 0;
        while (sent < 930) begin
            if (sent > 780) idle_on = 0;
            pick = $urandom_range(0, 19);
            x = $urandom_range(0, 4);
            y = $urandom_range(0, 3);
            z = $urandom_range(0, 3);
            if (pick == 0) begin
                x = $urandom_range(0, 1) ? 63 : 32;
                y = 1;
                z = $urandom_range(0, 1);
            end else if (pick == 1) begin
                x = 1;
                y = 32;
                z = 1;
            end else if (pick == 2) begin
                x = 0;
                y = 1;
                z = 32;
            end
            set_volume(x, y, z, $urandom_range(0, 1));
            total = volume_total();
            pick = $urandom_range(0, 9);
            if (pick == 0) n = $urandom_range(1, total);
            else if (pick == 1) n = total + $urandom_range(1, 6);
            else n = total;
            // a few stray loads without a sum
            if ($urandom_range(0, 7) == 0) begin
                for (int i = 0; i < 3; i++) send_random_voxel(0);
                sent += 3;
            end
            load_and_sum(n);
            sent += n;
        end

        // Drain
        s_tvalid <= 0;
        s_tlast  <= 0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
